[rtl/delayed_message_slot_table_defines.svh]
// assertion macros for the delayed message slot table
// used by the top level; no other dependencies
`ifndef DELAYED_MESSAGE_SLOT_TABLE_DEFINES_SVH
`define DELAYED_MESSAGE_SLOT_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define DMST_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("dmst assertion failed");
`define DMST_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("dmst assertion failed");
`else
`define DMST_ASSERT_IMP(label, clk, rst_n, a, b)
`define DMST_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

[rtl/dmst_pkg.sv]
// types and constants shared by the delayed message slot table
// no dependencies
`default_nettype none

package dmst_pkg;

    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 48;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic [2:0] {
        OP_SEND   = 3'd0,
        OP_OBTAIN = 3'd1,
        OP_ERASE  = 3'd2,
        OP_GET    = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_TICK   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wild_hit;
        logic exact_hit;
        logic due_hit;
    } t_match;

    typedef struct packed {
        logic               found;
        logic [3:0]         slot_index;
        logic [15:0]        out_target;
        logic [15:0]        out_code;
        logic signed [31:0] out_payload;
        logic               dropped;
        logic [4:0]         live_entries;
    } t_rsp;

endpackage

`default_nettype wire

[rtl/dmst_req_if.sv]
// request channel of the delayed message slot table
// no dependencies
`default_nettype none

interface dmst_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [15:0]        target;
    logic [15:0]        code;
    logic [31:0]        delay_ms;
    logic signed [31:0] payload;

    modport source (output valid, op, target, code, delay_ms, payload, input ready);
    modport sink   (input valid, op, target, code, delay_ms, payload, output ready);
endinterface

`default_nettype wire

[rtl/dmst_rsp_if.sv]
// response channel of the delayed message slot table
// no dependencies
`default_nettype none

interface dmst_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic [3:0]         slot_index;
    logic [15:0]        out_target;
    logic [15:0]        out_code;
    logic signed [31:0] out_payload;
    logic               dropped;
    logic [4:0]         live_entries;

    modport source (output valid, found, slot_index, out_target, out_code, out_payload,
                    dropped, live_entries, input ready);
    modport sink   (input valid, found, slot_index, out_target, out_code, out_payload,
                    dropped, live_entries, output ready);
endinterface

`default_nettype wire

[rtl/dmst_match_unit.sv]
// shared compare unit: checks one slot against the current request
// depends on dmst_pkg
`default_nettype none

module dmst_match_unit (
    input  wire logic                          i_valid,
    input  wire logic [15:0]                   i_slot_target,
    input  wire logic [15:0]                   i_slot_code,
    input  wire logic [dmst_pkg::TIME_BITS-1:0] i_slot_due,
    input  wire logic [15:0]                   i_target,
    input  wire logic [15:0]                   i_code,
    input  wire logic [dmst_pkg::TIME_BITS-1:0] i_now,
    output dmst_pkg::t_match                   o_match
);

    logic w_tgt_eq;
    logic w_code_eq;

    assign w_tgt_eq  = (i_slot_target == i_target);
    assign w_code_eq = (i_slot_code == i_code);

    always_comb begin
        o_match.wild_hit  = i_valid && w_tgt_eq && (w_code_eq || (i_code == 16'd0));
        o_match.exact_hit = i_valid && w_tgt_eq && w_code_eq;
        o_match.due_hit   = i_valid && (i_now >= i_slot_due);
    end

endmodule

`default_nettype wire

[rtl/delayed_message_slot_table.sv]
// delayed message slot table: top level with sequencer and slot storage
// depends on dmst_pkg, dmst_req_if, dmst_rsp_if, dmst_match_unit and the defines header
//
// usage
//   i_req carries one request (op, target, code, delay_ms, payload); o_rsp returns
//   exactly one response per request, in order
//   a single compare unit visits one slot per cycle, lowest slot first
//   send and erase visit all SLOTS slots; send then places the entry in S_PLACE,
//   or drops it if no slot is free; obtain and get stop at the first hit, or
//   after the last slot; clear, tick and unused ops skip the scan and go to S_DONE
//   the response is loaded from S_DONE into the output register, and the
//   sequencer then returns to idle before it accepts the next request
//   i_req.ready is high only while the sequencer is idle
//   a finished response waits in the output register; a stalled receiver holds
//   it there while the next request is accepted and worked on, and that request
//   waits in its final state until the register frees
//   reset empties the table, zeroes the clock and the count and drops any
//   pending response; slot contents are not cleared
`default_nettype none
`include "delayed_message_slot_table_defines.svh"

module delayed_message_slot_table (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dmst_req_if.sink    i_req,
    dmst_rsp_if.source  o_rsp
);

    localparam int SLOTS     = dmst_pkg::SLOTS;
    localparam int TIME_BITS = dmst_pkg::TIME_BITS;
    localparam int IDX_W     = dmst_pkg::IDX_W;
    localparam int CNT_W     = dmst_pkg::CNT_W;

    // slot storage
    logic [15:0]          r_tgt_mem [SLOTS];
    logic [15:0]          r_code_mem [SLOTS];
    logic [TIME_BITS-1:0] r_due_mem [SLOTS];
    logic signed [31:0]   r_pay_mem [SLOTS];

    logic [15:0]          r_rd_tgt;
    logic [15:0]          r_rd_code;
    logic [TIME_BITS-1:0] r_rd_due;
    logic signed [31:0]   r_rd_pay;

    dmst_pkg::t_state     r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [2:0]           r_op, n_op;
    logic [15:0]          r_target, n_target;
    logic [15:0]          r_code, n_code;
    logic [31:0]          r_delay, n_delay;
    logic signed [31:0]   r_payload, n_payload;
    logic [SLOTS-1:0]     r_valid, n_valid;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic                 r_free_found, n_free_found;
    logic [IDX_W-1:0]     r_free_idx, n_free_idx;
    logic                 r_res_found, n_res_found;
    logic [IDX_W-1:0]     r_res_idx, n_res_idx;
    logic [15:0]          r_res_target, n_res_target;
    logic [15:0]          r_res_code, n_res_code;
    logic signed [31:0]   r_res_payload, n_res_payload;
    logic                 r_res_dropped, n_res_dropped;
    logic                 r_rsp_valid, n_rsp_valid;
    dmst_pkg::t_rsp       r_rsp, n_rsp;

    logic                 w_mem_we;
    logic                 w_last;
    logic [TIME_BITS:0]   w_due_sum;
    logic [TIME_BITS-1:0] w_due;
    dmst_pkg::t_match     w_match;

    dmst_match_unit u_match (
        .i_valid       (r_valid[r_idx]),
        .i_slot_target (r_rd_tgt),
        .i_slot_code   (r_rd_code),
        .i_slot_due    (r_rd_due),
        .i_target      (r_target),
        .i_code        (r_code),
        .i_now         (r_now),
        .o_match       (w_match)
    );

    assign w_last    = (r_idx == IDX_W'(SLOTS - 1));
    assign w_due_sum = {1'b0, r_now} + (TIME_BITS + 1)'(r_delay);
    assign w_due     = w_due_sum[TIME_BITS] ? dmst_pkg::TIME_MAX : w_due_sum[TIME_BITS-1:0];

    assign i_req.ready        = (r_state == dmst_pkg::S_IDLE);
    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.found        = r_rsp.found;
    assign o_rsp.slot_index   = r_rsp.slot_index;
    assign o_rsp.out_target   = r_rsp.out_target;
    assign o_rsp.out_code     = r_rsp.out_code;
    assign o_rsp.out_payload  = r_rsp.out_payload;
    assign o_rsp.dropped      = r_rsp.dropped;
    assign o_rsp.live_entries = r_rsp.live_entries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmst_pkg::S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_now       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_now       <= n_now;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_op          <= n_op;
        r_target      <= n_target;
        r_code        <= n_code;
        r_delay       <= n_delay;
        r_payload     <= n_payload;
        r_free_found  <= n_free_found;
        r_free_idx    <= n_free_idx;
        r_res_found   <= n_res_found;
        r_res_idx     <= n_res_idx;
        r_res_target  <= n_res_target;
        r_res_code    <= n_res_code;
        r_res_payload <= n_res_payload;
        r_res_dropped <= n_res_dropped;
        r_rsp         <= n_rsp;
    end

    // slot data for the next scan index is read from n_idx into the r_rd registers, ready when that index is scanned
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_tgt_mem[r_free_idx]  <= r_target;
            r_code_mem[r_free_idx] <= r_code;
            r_due_mem[r_free_idx]  <= w_due;
            r_pay_mem[r_free_idx]  <= r_payload;
        end
        r_rd_tgt  <= r_tgt_mem[n_idx];
        r_rd_code <= r_code_mem[n_idx];
        r_rd_due  <= r_due_mem[n_idx];
        r_rd_pay  <= r_pay_mem[n_idx];
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_op          = r_op;
        n_target      = r_target;
        n_code        = r_code;
        n_delay       = r_delay;
        n_payload     = r_payload;
        n_valid       = r_valid;
        n_count       = r_count;
        n_now         = r_now;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_res_found   = r_res_found;
        n_res_idx     = r_res_idx;
        n_res_target  = r_res_target;
        n_res_code    = r_res_code;
        n_res_payload = r_res_payload;
        n_res_dropped = r_res_dropped;
        n_rsp         = r_rsp;
        n_rsp_valid   = r_rsp_valid && !o_rsp.ready;
        w_mem_we      = 1'b0;

        unique case (r_state)
            dmst_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_op          = i_req.op;
                    n_target      = i_req.target;
                    n_code        = i_req.code;
                    n_delay       = i_req.delay_ms;
                    n_payload     = i_req.payload;
                    n_idx         = '0;
                    n_free_found  = 1'b0;
                    n_res_found   = 1'b0;
                    n_res_idx     = '0;
                    n_res_target  = '0;
                    n_res_code    = '0;
                    n_res_payload = '0;
                    n_res_dropped = 1'b0;
                    n_state       = dmst_pkg::S_DONE;
                    unique case (i_req.op)
                        dmst_pkg::OP_SEND, dmst_pkg::OP_OBTAIN,
                        dmst_pkg::OP_ERASE, dmst_pkg::OP_GET: begin
                            n_state = dmst_pkg::S_SCAN;
                        end
                        dmst_pkg::OP_CLEAR: begin
                            n_valid = '0;
                            n_count = '0;
                        end
                        dmst_pkg::OP_TICK: begin
                            if (r_now != dmst_pkg::TIME_MAX) begin
                                n_now = r_now + TIME_BITS'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            dmst_pkg::S_SCAN: begin
                n_idx = r_idx + IDX_W'(1);
                unique case (r_op)
                    dmst_pkg::OP_SEND, dmst_pkg::OP_ERASE: begin
                        if (w_match.wild_hit) begin
                            n_valid[r_idx] = 1'b0;
                            n_count        = r_count - CNT_W'(1);
                        end
                        // lowest slot that is free once this pass has removed its matches
                        if (!r_free_found && (!r_valid[r_idx] || w_match.wild_hit)) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_idx;
                        end
                        if (w_last) begin
                            n_state = (r_op == dmst_pkg::OP_SEND) ? dmst_pkg::S_PLACE
                                                                  : dmst_pkg::S_DONE;
                        end
                    end
                    dmst_pkg::OP_OBTAIN, dmst_pkg::OP_GET: begin
                        if ((r_op == dmst_pkg::OP_OBTAIN) ? w_match.due_hit
                                                          : w_match.exact_hit) begin
                            n_res_found   = 1'b1;
                            n_res_idx     = r_idx;
                            n_res_target  = r_rd_tgt;
                            n_res_code    = r_rd_code;
                            n_res_payload = r_rd_pay;
                            n_state       = dmst_pkg::S_DONE;
                            if (r_op == dmst_pkg::OP_OBTAIN) begin
                                n_valid[r_idx] = 1'b0;
                                n_count        = r_count - CNT_W'(1);
                            end
                        end else if (w_last) begin
                            n_state = dmst_pkg::S_DONE;
                        end
                    end
                    default: begin
                        n_state = dmst_pkg::S_DONE;
                    end
                endcase
            end

            dmst_pkg::S_PLACE: begin
                if (r_free_found) begin
                    w_mem_we            = 1'b1;
                    n_valid[r_free_idx] = 1'b1;
                    n_count             = r_count + CNT_W'(1);
                    n_res_idx           = r_free_idx;
                end else begin
                    n_res_dropped = 1'b1;
                end
                n_state = dmst_pkg::S_DONE;
            end

            dmst_pkg::S_DONE: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp.found        = r_res_found;
                    n_rsp.slot_index   = 4'(r_res_idx);
                    n_rsp.out_target   = r_res_target;
                    n_rsp.out_code     = r_res_code;
                    n_rsp.out_payload  = r_res_payload;
                    n_rsp.dropped      = r_res_dropped;
                    n_rsp.live_entries = 5'(r_count);
                    n_rsp_valid        = 1'b1;
                    n_state            = dmst_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = dmst_pkg::S_IDLE;
            end
        endcase
    end

    `DMST_ASSERT_IMP(a_count_matches_valid, i_clk, i_rst_n, 1'b1,
                     r_count == CNT_W'($countones(r_valid)))
    `DMST_ASSERT_IMP(a_found_not_dropped, i_clk, i_rst_n, r_rsp_valid,
                     !(r_rsp.found && r_rsp.dropped))
    `DMST_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_req.valid && i_req.ready,
                      r_state != dmst_pkg::S_IDLE)

endmodule

`default_nettype wire
